FILE: src/bls_pkg.sv
// ----------------------------------------------------------------------------
// bls_pkg
// Shared types and constants for the Bresenham line stepper.
// ----------------------------------------------------------------------------
package bls_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int ERR_GUARD_BITS = 4;
  localparam int COLOR_BITS     = 32;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic to_second;
    logic last;
  } step_ctl_t;

endpackage

FILE: src/bls_load.sv
// ----------------------------------------------------------------------------
// bls_load
// Line setup: deltas, step directions, initial error and the active flag.
// ----------------------------------------------------------------------------
module bls_load #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int ERR_BITS   = COORD_BITS + bls_pkg::ERR_GUARD_BITS
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic                  y_major,
  output logic [COORD_BITS-1:0] delta_x,
  output logic [COORD_BITS-1:0] delta_y,
  output logic                  dir_x_negative,
  output logic                  dir_y_negative,
  output logic [ERR_BITS-1:0]   error_init,
  output logic                  active
);

  logic [ERR_BITS-1:0] dmaj_ext;
  logic [ERR_BITS-1:0] dmin2_ext;

  always_comb begin
    dir_x_negative = !(end_x > start_x);
    dir_y_negative = !(end_y > start_y);
    delta_x = dir_x_negative ? (start_x - end_x) : (end_x - start_x);
    delta_y = dir_y_negative ? (start_y - end_y) : (end_y - start_y);
    if (y_major) begin
      dmaj_ext  = ERR_BITS'(delta_y);
      dmin2_ext = ERR_BITS'({delta_x, 1'b0});
      active    = (start_y != end_y);
    end else begin
      dmaj_ext  = ERR_BITS'(delta_x);
      dmin2_ext = ERR_BITS'({delta_y, 1'b0});
      active    = (start_x != end_x);
    end
    error_init = dmin2_ext - dmaj_ext;
  end

endmodule

FILE: src/bls_step.sv
// ----------------------------------------------------------------------------
// bls_step
// One Bresenham step: next coordinates, next error, color switch and last flag.
// ----------------------------------------------------------------------------
module bls_step #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF,
  parameter int ERR_BITS   = COORD_BITS + bls_pkg::ERR_GUARD_BITS
) (
  input  logic [COORD_BITS-1:0] cur_x,
  input  logic [COORD_BITS-1:0] cur_y,
  input  logic [COORD_BITS-1:0] target_x,
  input  logic [COORD_BITS-1:0] target_y,
  input  logic [COORD_BITS-1:0] delta_x,
  input  logic [COORD_BITS-1:0] delta_y,
  input  logic                  dir_x_negative,
  input  logic                  dir_y_negative,
  input  logic                  axis_is_y,
  input  logic [ERR_BITS-1:0]   error_term,
  output logic [COORD_BITS-1:0] cur_x_next,
  output logic [COORD_BITS-1:0] cur_y_next,
  output logic [ERR_BITS-1:0]   error_term_next,
  output bls_pkg::step_ctl_t    ctl
);

  logic [COORD_BITS-1:0] maj;
  logic [COORD_BITS-1:0] mnr;
  logic [COORD_BITS-1:0] maj_end;
  logic [COORD_BITS-1:0] dmaj;
  logic [COORD_BITS-1:0] dmin;
  logic                  maj_neg;
  logic                  mnr_neg;
  logic [COORD_BITS-1:0] maj_dist;
  logic                  minor_move;
  logic [COORD_BITS-1:0] maj_next;
  logic [COORD_BITS-1:0] mnr_next;
  logic [ERR_BITS-1:0]   err_adj;

  always_comb begin
    maj     = axis_is_y ? cur_y : cur_x;
    mnr     = axis_is_y ? cur_x : cur_y;
    maj_end = axis_is_y ? target_y : target_x;
    dmaj    = axis_is_y ? delta_y : delta_x;
    dmin    = axis_is_y ? delta_x : delta_y;
    maj_neg = axis_is_y ? dir_y_negative : dir_x_negative;
    mnr_neg = axis_is_y ? dir_x_negative : dir_y_negative;

    maj_dist = (maj > maj_end) ? (maj - maj_end) : (maj_end - maj);
    ctl.to_second = (maj_dist == (dmaj >> 1));

    // error strictly positive
    minor_move = !error_term[ERR_BITS-1] && (error_term != '0);
    mnr_next   = minor_move ? (mnr_neg ? mnr - 1'b1 : mnr + 1'b1) : mnr;
    err_adj    = minor_move ? error_term - ERR_BITS'({dmaj, 1'b0}) : error_term;
    error_term_next = err_adj + ERR_BITS'({dmin, 1'b0});

    maj_next = maj_neg ? maj - 1'b1 : maj + 1'b1;
    ctl.last = (maj_next == maj_end);

    cur_x_next = axis_is_y ? mnr_next : maj_next;
    cur_y_next = axis_is_y ? maj_next : mnr_next;
  end

endmodule

FILE: src/bresenham_line_stepper.sv
// A step transfer on an active line goes through the input register and then the
// result register before its pixel shows on out_valid.
// Throughput: one command per cycle while the result is not stalled; the line setup
// and the step are each a few adds, subtracts and compares ahead of the line state.
// Reset clears the input and result valid flags and the active flag; the block
// is idle after reset and steps give no pixels until a line is loaded.
// ----------------------------------------------------------------------------
// bresenham_line_stepper
// Integer line rasterizer: a load command sets up a line, each step command on an
// active line gives one pixel with its color and a last-pixel flag.
// ----------------------------------------------------------------------------
module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [COORD_BITS-1:0]          start_x,
  input  logic [COORD_BITS-1:0]          start_y,
  input  logic [COORD_BITS-1:0]          end_x,
  input  logic [COORD_BITS-1:0]          end_y,
  input  logic                           y_major,
  input  logic [bls_pkg::COLOR_BITS-1:0] start_color,
  input  logic [bls_pkg::COLOR_BITS-1:0] end_color,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [COORD_BITS-1:0]          pixel_x,
  output logic [COORD_BITS-1:0]          pixel_y,
  output logic [bls_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                           last_pixel
);

  localparam int ERR_BITS = COORD_BITS + bls_pkg::ERR_GUARD_BITS;

  // input register
  logic                           ir_valid;
  logic                           ir_op;
  logic [COORD_BITS-1:0]          ir_start_x;
  logic [COORD_BITS-1:0]          ir_start_y;
  logic [COORD_BITS-1:0]          ir_end_x;
  logic [COORD_BITS-1:0]          ir_end_y;
  logic                           ir_y_major;
  logic [bls_pkg::COLOR_BITS-1:0] ir_start_color;
  logic [bls_pkg::COLOR_BITS-1:0] ir_end_color;

  // line state
  logic [COORD_BITS-1:0]          cur_x;
  logic [COORD_BITS-1:0]          cur_y;
  logic [COORD_BITS-1:0]          target_x;
  logic [COORD_BITS-1:0]          target_y;
  logic [COORD_BITS-1:0]          delta_x;
  logic [COORD_BITS-1:0]          delta_y;
  logic                           dir_x_negative;
  logic                           dir_y_negative;
  logic [ERR_BITS-1:0]            error_term;
  logic                           axis_is_y;
  logic [bls_pkg::COLOR_BITS-1:0] draw_color;
  logic [bls_pkg::COLOR_BITS-1:0] second_color;
  logic                           line_active;

  // load and step results
  logic [COORD_BITS-1:0]          ld_delta_x;
  logic [COORD_BITS-1:0]          ld_delta_y;
  logic                           ld_dir_x_negative;
  logic                           ld_dir_y_negative;
  logic [ERR_BITS-1:0]            ld_error;
  logic                           ld_active;
  logic [COORD_BITS-1:0]          cur_x_next;
  logic [COORD_BITS-1:0]          cur_y_next;
  logic [ERR_BITS-1:0]            error_term_next;
  bls_pkg::step_ctl_t             step_ctl;

  logic                           res_free;
  logic                           fire;
  logic                           do_load;
  logic                           do_step;
  logic                           in_xfer;

  assign res_free = !out_valid || !out_stall;
  assign fire     = ir_valid && res_free;
  assign do_load  = fire && (ir_op == bls_pkg::OP_LOAD);
  assign do_step  = fire && (ir_op == bls_pkg::OP_STEP) && line_active;
  assign in_stall = ir_valid && !fire;
  assign in_xfer  = in_valid && !in_stall;

  bls_load #(
    .COORD_BITS (COORD_BITS),
    .ERR_BITS   (ERR_BITS)
  ) u_load (
    .start_x        (ir_start_x),
    .start_y        (ir_start_y),
    .end_x          (ir_end_x),
    .end_y          (ir_end_y),
    .y_major        (ir_y_major),
    .delta_x        (ld_delta_x),
    .delta_y        (ld_delta_y),
    .dir_x_negative (ld_dir_x_negative),
    .dir_y_negative (ld_dir_y_negative),
    .error_init     (ld_error),
    .active         (ld_active)
  );

  bls_step #(
    .COORD_BITS (COORD_BITS),
    .ERR_BITS   (ERR_BITS)
  ) u_step (
    .cur_x           (cur_x),
    .cur_y           (cur_y),
    .target_x        (target_x),
    .target_y        (target_y),
    .delta_x         (delta_x),
    .delta_y         (delta_y),
    .dir_x_negative  (dir_x_negative),
    .dir_y_negative  (dir_y_negative),
    .axis_is_y       (axis_is_y),
    .error_term      (error_term),
    .cur_x_next      (cur_x_next),
    .cur_y_next      (cur_y_next),
    .error_term_next (error_term_next),
    .ctl             (step_ctl)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_xfer) begin
      ir_valid <= 1'b1;
    end else if (fire) begin
      ir_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ir_op          <= opcode;
      ir_start_x     <= start_x;
      ir_start_y     <= start_y;
      ir_end_x       <= end_x;
      ir_end_y       <= end_y;
      ir_y_major     <= y_major;
      ir_start_color <= start_color;
      ir_end_color   <= end_color;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (do_load) begin
      line_active <= ld_active;
    end else if (do_step && step_ctl.last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      cur_x          <= ir_start_x;
      cur_y          <= ir_start_y;
      target_x       <= ir_end_x;
      target_y       <= ir_end_y;
      delta_x        <= ld_delta_x;
      delta_y        <= ld_delta_y;
      dir_x_negative <= ld_dir_x_negative;
      dir_y_negative <= ld_dir_y_negative;
      error_term     <= ld_error;
      axis_is_y      <= ir_y_major;
      draw_color     <= ir_start_color;
      second_color   <= ir_end_color;
    end else if (do_step) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= error_term_next;
      if (step_ctl.to_second) begin
        draw_color <= second_color;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_color <= draw_color;
      last_pixel  <= step_ctl.last;
    end
  end

`ifndef SYNTHESIS
  a_step_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    do_step |=> out_valid)
    else $error("step on an active line gave no pixel");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (do_step && step_ctl.last) |=> !line_active)
    else $error("line still active after its last pixel");

  a_stall_holds_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(pixel_x) && $stable(pixel_y))
    else $error("stalled pixel changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && !ir_valid && !line_active)
    else $error("control state not cleared by reset");
`endif

endmodule
